// ===== design/apfd_pkg.sv =====
`timescale 1ns / 1ps
package apfd_pkg;

	// register indexes on the configuration channel
	localparam logic [2:0] REG_SETPOINT  = 3'd0;
	localparam logic [2:0] REG_GAIN_P    = 3'd1;
	localparam logic [2:0] REG_GAIN_I    = 3'd2;
	localparam logic [2:0] REG_GAIN_D    = 3'd3;
	localparam logic [2:0] REG_INT_LIMIT = 3'd4;
	localparam logic [2:0] REG_OUT_LIMIT = 3'd5;

	// reset values of the registers
	localparam logic signed [15:0] SETPOINT_RST  = 16'sd30;
	localparam logic signed [23:0] GAIN_P_RST    = 24'sd94720;
	localparam logic signed [23:0] GAIN_I_RST    = 24'sd0;
	localparam logic signed [23:0] GAIN_D_RST    = -24'sd563;
	localparam logic [14:0]        INT_LIMIT_RST = 15'd30000;
	localparam logic [14:0]        OUT_LIMIT_RST = 15'd6900;

	// rate filter coefficients in Q8
	localparam logic signed [23:0] FILT_OLD = 24'sd51;
	localparam logic signed [23:0] FILT_NEW = 24'sd205;

	typedef struct packed {
		logic signed [15:0] setpoint;
		logic signed [23:0] gain_p;
		logic signed [23:0] gain_i;
		logic signed [23:0] gain_d;
		logic [14:0]        int_limit;
		logic [14:0]        out_limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] drive;
		logic               saturated;
	} res_t;

endpackage

// ===== design/apfd_if.sv =====
`timescale 1ns / 1ps
// measurement channel: one angle and rate word per control tick
interface apfd_meas_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] angle;
	logic signed [15:0] rate;
	modport source (output valid, output angle, output rate, input ready);
	modport sink (input valid, input angle, input rate, output ready);
endinterface

// drive channel: one result word per tick
interface apfd_drive_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] drive;
	logic               saturated;
	modport source (output valid, output drive, output saturated, input ready);
	modport sink (input valid, input drive, input saturated, output ready);
endinterface

// configuration write channel
interface apfd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/apfd_mul.sv =====
`timescale 1ns / 1ps
module apfd_mul (
	input  logic               clk,
	input  logic signed [23:0] a,
	input  logic signed [23:0] b,
	output logic signed [47:0] p_q
);

	// shared signed multiplier with registered product
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

// ===== design/apfd_core.sv =====
`timescale 1ns / 1ps
module apfd_core import apfd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	apfd_meas_if.sink meas,
	output logic   res_valid,
	output res_t   res,
	input  logic   res_ready
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_FILT  = 4'd1;
	localparam logic [3:0] ST_RATE  = 4'd2;
	localparam logic [3:0] ST_DCALC = 4'd3;
	localparam logic [3:0] ST_ACCP  = 4'd4;
	localparam logic [3:0] ST_ACCI  = 4'd5;
	localparam logic [3:0] ST_ACCD  = 4'd6;
	localparam logic [3:0] ST_SCALE = 4'd7;
	localparam logic [3:0] ST_DONE  = 4'd8;

	logic [3:0]         state_q;
	logic signed [16:0] err_q;
	logic signed [15:0] rate_q;
	logic signed [15:0] sum_q;
	logic signed [23:0] filt_q;
	logic signed [23:0] tmp_q;
	logic signed [51:0] acc_q;
	logic signed [35:0] raw_q;

	logic signed [23:0] mul_a;
	logic signed [23:0] mul_b;
	logic signed [47:0] prod;

	logic signed [17:0] sum_next;
	logic signed [17:0] int_lim;
	logic signed [47:0] round_p;
	logic signed [24:0] d_next;
	logic signed [51:0] acc_bias;
	logic signed [35:0] out_lim;

	apfd_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign meas.ready = (state_q == ST_IDLE);

	// operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_FILT: begin
				mul_a = filt_q;
				mul_b = FILT_OLD;
			end
			ST_RATE: begin
				mul_a = {{8{rate_q[15]}}, rate_q};
				mul_b = FILT_NEW;
			end
			ST_DCALC: begin
				mul_a = {{7{err_q[16]}}, err_q};
				mul_b = cfg.gain_p;
			end
			ST_ACCP: begin
				mul_a = {{8{sum_q[15]}}, sum_q};
				mul_b = cfg.gain_i;
			end
			ST_ACCI: begin
				mul_a = filt_q;
				mul_b = cfg.gain_d;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// arithmetic helpers
	assign sum_next = {sum_q[15], sum_q[15], sum_q} + {err_q[16], err_q};
	assign int_lim  = {3'b000, cfg.int_limit};
	assign round_p  = prod + 48'sd128;
	assign d_next   = {tmp_q[23], tmp_q} + {prod[23], prod[23:0]};
	assign acc_bias = acc_q[51] ? (acc_q + 52'sd65535) : acc_q;
	assign out_lim  = {21'd0, cfg.out_limit};

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			err_q     <= '0;
			rate_q    <= '0;
			sum_q     <= '0;
			filt_q    <= '0;
			tmp_q     <= '0;
			acc_q     <= '0;
			raw_q     <= '0;
			res_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					res_valid <= 1'b0;
					if (meas.valid) begin
						err_q   <= {meas.angle[15], meas.angle} -
						           {cfg.setpoint[15], cfg.setpoint};
						rate_q  <= meas.rate;
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					// clamped integral update
					if (sum_next > int_lim)
						sum_q <= int_lim[15:0];
					else if (sum_next < -int_lim)
						sum_q <= -int_lim[15:0];
					else
						sum_q <= sum_next[15:0];
					state_q <= ST_RATE;
				end
				ST_RATE: begin
					// 51*d/256 rounded, ties up
					tmp_q   <= round_p[31:8];
					state_q <= ST_DCALC;
				end
				ST_DCALC: begin
					if (d_next > 25'sd8388607)
						filt_q <= 24'sh7FFFFF;
					else if (d_next < -25'sd8388608)
						filt_q <= 24'sh800000;
					else
						filt_q <= d_next[23:0];
					state_q <= ST_ACCP;
				end
				ST_ACCP: begin
					acc_q   <= {prod[43:0], 8'd0};
					state_q <= ST_ACCI;
				end
				ST_ACCI: begin
					acc_q   <= acc_q + {prod[43:0], 8'd0};
					state_q <= ST_ACCD;
				end
				ST_ACCD: begin
					acc_q   <= acc_q + {{4{prod[47]}}, prod};
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					// divide by 65536 toward zero
					raw_q   <= acc_bias[51:16];
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					res_valid <= 1'b1;
					if (res_valid && res_ready) begin
						res_valid <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output clip against the drive limit
	always_comb begin
		if (raw_q > out_lim) begin
			res.drive     = out_lim[15:0];
			res.saturated = 1'b1;
		end else if (raw_q < -out_lim) begin
			res.drive     = -out_lim[15:0];
			res.saturated = 1'b1;
		end else begin
			res.drive     = raw_q[15:0];
			res.saturated = 1'b0;
		end
	end

endmodule

// ===== design/attitude_pid_filtered_derivative.sv =====
`timescale 1ns / 1ps
// One-axis attitude PID with low-pass filtered rate and clamped integral.
// Channels: meas (sink) takes one angle and rate word per control tick,
// drive (source) gives one drive word with a saturation flag per tick,
// cfg (sink) writes the six registers by index; it is always ready and
// unknown indexes are ignored.
// Sequence: after a word is accepted on meas, the sequencer runs seven
// steps (FILT, RATE, DCALC, ACCP, ACCI, ACCD, SCALE) that use the shared
// 24x24 multiplier for two filter products and three gain products and
// then scale the sum; DONE flags the clipped result, which goes through
// the output register to drive.valid.
// Flow: a new word is taken only once the previous one has left the
// sequencer; meas is ready only while the sequencer is idle.
// Stall: the finished word waits in the output register; a new word is
// accepted as soon as the previous one is handed to the output register.
// Reset: registers take their default values, integral and filtered rate
// clear to zero and no drive word is pending.
module attitude_pid_filtered_derivative import apfd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	apfd_cfg_if.sink    cfg,
	apfd_meas_if.sink   meas,
	apfd_drive_if.source drive
);

	cfg_t  cfg_q;
	logic  res_valid;
	res_t  res;
	logic  res_ready;
	logic  out_valid_q;
	res_t  out_q;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint  <= SETPOINT_RST;
			cfg_q.gain_p    <= GAIN_P_RST;
			cfg_q.gain_i    <= GAIN_I_RST;
			cfg_q.gain_d    <= GAIN_D_RST;
			cfg_q.int_limit <= INT_LIMIT_RST;
			cfg_q.out_limit <= OUT_LIMIT_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SETPOINT:  cfg_q.setpoint  <= cfg.data[15:0];
				REG_GAIN_P:    cfg_q.gain_p    <= cfg.data;
				REG_GAIN_I:    cfg_q.gain_i    <= cfg.data;
				REG_GAIN_D:    cfg_q.gain_d    <= cfg.data;
				REG_INT_LIMIT: cfg_q.int_limit <= cfg.data[14:0];
				REG_OUT_LIMIT: cfg_q.out_limit <= cfg.data[14:0];
				default: begin
				end
			endcase
		end
	end

	apfd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.meas      (meas),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	// output register, frees the sequencer while the receiver stalls
	assign res_ready = !out_valid_q || drive.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign drive.valid     = out_valid_q;
	assign drive.drive     = out_q.drive;
	assign drive.saturated = out_q.saturated;

endmodule
